// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types, constants and the divider step for the RGB/HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

   // Hue sector geometry, 8-bit scale
   localparam logic [7:0] HUE_SECTOR   = 8'd43;
   localparam logic [7:0] HUE_GREEN    = 8'd85;
   localparam logic [7:0] HUE_BLUE     = 8'd171;
   localparam logic [7:0] FULL_SCALE   = 8'd255;
   localparam logic [7:0] REGION_COUNT = 8'd6;

   // Pipeline depths: forward converter, back converter, whole block
   localparam int unsigned CONV_STAGES = 7;
   localparam int unsigned BACK_STAGES = 4;
   localparam int unsigned LATENCY     = CONV_STAGES + BACK_STAGES;

   typedef enum logic [1:0] {
      OP_RGB2HSV = 2'd0,
      OP_HSV2RGB = 2'd1,
      OP_DARKEN  = 2'd2,
      OP_PASS    = 2'd3
   } op_type;

   // Request fields carried alongside the pipeline
   typedef struct packed {
      op_type     op;
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [7:0] amount;
   } side_type;

   // Control group between top and converter
   typedef struct packed {
      logic     valid;
      side_type side;
   } tag_type;

   typedef struct packed {
      logic [7:0] rem;
      logic       bit_q;
   } div_step_type;

   // One restoring division step: a partial remainder below a nonzero divisor stays below it
   function automatic div_step_type div_step(input logic [7:0] rem,
                                             input logic       dvd_bit,
                                             input logic [7:0] dvsr);
      logic [8:0]   trial;
      div_step_type res;
      trial = {rem, dvd_bit};
      if (trial >= {1'b0, dvsr}) begin
         res.rem   = 8'(trial - {1'b0, dvsr});
         res.bit_q = 1'b1;
      end else begin
         res.rem   = trial[7:0];
         res.bit_q = 1'b0;
      end
      return res;
   endfunction

endpackage

// ===== rtl/rhc_rgb2hsv.sv =====
// ----------------------------------------------------------------------------
// rhc_rgb2hsv
// Pipelined RGB to HSV converter: min/max, dividend set-up, two 2-bit-per-
// stage restoring dividers (saturation and hue), then hue/special-case fix-up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhc_rgb2hsv
   import rhc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  tag_type    in_tag,
   output tag_type    out_tag,
   output logic [7:0] out_h,
   output logic [7:0] out_s,
   output logic [7:0] out_v
);

   typedef enum logic [1:0] {
      MAX_RED   = 2'd0,
      MAX_GREEN = 2'd1,
      MAX_BLUE  = 2'd2
   } max_type;

   typedef struct packed {
      logic [7:0] hi;
      logic [7:0] span;
      logic [7:0] mag;
      logic       neg;
      max_type    maxsel;
      logic       black;
      logic       grey;
   } mm_type;

   // Divider lanes: rem is the partial remainder, low holds the unused
   // dividend bits on top and the quotient bits shifted in below
   typedef struct packed {
      logic [7:0] sat_rem;
      logic [7:0] sat_low;
      logic [7:0] hue_rem;
      logic [7:0] hue_low;
      logic [7:0] hi;
      logic [7:0] span;
      logic       neg;
      max_type    maxsel;
      logic       black;
      logic       grey;
   } div_stage_type;

   localparam int unsigned DIV_STEPS = 4;

   tag_type       mm_tag_ff;
   mm_type        mm_ff, mm_in;
   tag_type       dv_tag_ff [0:DIV_STEPS];
   div_stage_type dv_ff     [0:DIV_STEPS];
   div_stage_type dv_in     [0:DIV_STEPS];
   tag_type       out_tag_ff;
   logic [7:0]    h_ff, h_in;
   logic [7:0]    s_ff, s_in;
   logic [7:0]    v_ff, v_in;

   // Stage 1: extremes, span and signed hue offset as sign/magnitude
   always_comb begin
      logic [7:0] r, g, b, lo, hi, a, c;
      r = in_tag.side.c0;
      g = in_tag.side.c1;
      b = in_tag.side.c2;
      lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
      hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
      if (hi == r) begin
         mm_in.maxsel = MAX_RED;
         a = g;
         c = b;
      end else if (hi == g) begin
         mm_in.maxsel = MAX_GREEN;
         a = b;
         c = r;
      end else begin
         mm_in.maxsel = MAX_BLUE;
         a = r;
         c = g;
      end
      mm_in.hi    = hi;
      mm_in.span  = hi - lo;
      mm_in.neg   = (a < c);
      mm_in.mag   = (a < c) ? (c - a) : (a - c);
      mm_in.black = (hi == 8'd0);
      mm_in.grey  = (hi == lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mm_tag_ff.valid <= 1'b0;
      end else begin
         mm_tag_ff.valid <= in_tag.valid;
      end
      mm_tag_ff.side <= in_tag.side;
      mm_ff          <= mm_in;
   end

   // Stage 2: dividends 255*span and 43*|offset|, both below 256*divisor
   always_comb begin
      logic [15:0] sat_dvd, hue_dvd;
      sat_dvd = {mm_ff.span, 8'h00} - {8'h00, mm_ff.span};
      hue_dvd = 16'({8'h00, mm_ff.mag} * {8'h00, HUE_SECTOR});
      dv_in[0].sat_rem = sat_dvd[15:8];
      dv_in[0].sat_low = sat_dvd[7:0];
      dv_in[0].hue_rem = hue_dvd[15:8];
      dv_in[0].hue_low = hue_dvd[7:0];
      dv_in[0].hi      = mm_ff.hi;
      dv_in[0].span    = mm_ff.span;
      dv_in[0].neg     = mm_ff.neg;
      dv_in[0].maxsel  = mm_ff.maxsel;
      dv_in[0].black   = mm_ff.black;
      dv_in[0].grey    = mm_ff.grey;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_tag_ff[0].valid <= 1'b0;
      end else begin
         dv_tag_ff[0].valid <= mm_tag_ff.valid;
      end
      dv_tag_ff[0].side <= mm_tag_ff.side;
      dv_ff[0]          <= dv_in[0];
   end

   // Stages 3 to 6: two quotient bits per stage in each divider
   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      always_comb begin
         div_step_type sa, sb, ha, hb;
         sa = div_step(dv_ff[k-1].sat_rem, dv_ff[k-1].sat_low[7], dv_ff[k-1].hi);
         sb = div_step(sa.rem, dv_ff[k-1].sat_low[6], dv_ff[k-1].hi);
         ha = div_step(dv_ff[k-1].hue_rem, dv_ff[k-1].hue_low[7], dv_ff[k-1].span);
         hb = div_step(ha.rem, dv_ff[k-1].hue_low[6], dv_ff[k-1].span);
         dv_in[k]         = dv_ff[k-1];
         dv_in[k].sat_rem = sb.rem;
         dv_in[k].sat_low = {dv_ff[k-1].sat_low[5:0], sa.bit_q, sb.bit_q};
         dv_in[k].hue_rem = hb.rem;
         dv_in[k].hue_low = {dv_ff[k-1].hue_low[5:0], ha.bit_q, hb.bit_q};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_tag_ff[k].valid <= 1'b0;
         end else begin
            dv_tag_ff[k].valid <= dv_tag_ff[k-1].valid;
         end
         dv_tag_ff[k].side <= dv_tag_ff[k-1].side;
         dv_ff[k]          <= dv_in[k];
      end
   end

   // Stage 7: sector base plus signed quotient, black and grey short paths
   always_comb begin
      logic [7:0] base, quo;
      case (dv_ff[DIV_STEPS].maxsel)
         MAX_RED:   base = 8'd0;
         MAX_GREEN: base = HUE_GREEN;
         MAX_BLUE:  base = HUE_BLUE;
         default:   base = 8'd0;
      endcase
      quo = dv_ff[DIV_STEPS].hue_low;
      if (dv_ff[DIV_STEPS].black) begin
         h_in = 8'd0;
         s_in = 8'd0;
         v_in = 8'd0;
      end else if (dv_ff[DIV_STEPS].grey || (dv_ff[DIV_STEPS].sat_low == 8'd0)) begin
         h_in = 8'd0;
         s_in = 8'd0;
         v_in = dv_ff[DIV_STEPS].hi;
      end else begin
         h_in = dv_ff[DIV_STEPS].neg ? (base - quo) : (base + quo);
         s_in = dv_ff[DIV_STEPS].sat_low;
         v_in = dv_ff[DIV_STEPS].hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_tag_ff.valid <= 1'b0;
      end else begin
         out_tag_ff.valid <= dv_tag_ff[DIV_STEPS].valid;
      end
      out_tag_ff.side <= dv_tag_ff[DIV_STEPS].side;
      h_ff            <= h_in;
      s_ff            <= s_in;
      v_ff            <= v_in;
   end

   assign out_tag = out_tag_ff;
   assign out_h   = h_ff;
   assign out_s   = s_ff;
   assign out_v   = v_ff;

   // Checks
   `ASSERT_IMPL(a_zero_sat_zero_hue, clock, reset, out_tag.valid && (out_s == 8'd0), out_h == 8'd0)
   `ASSERT_IMPL(a_value_is_max, clock, reset, out_tag.valid, (out_v >= out_tag.side.c0) && (out_v >= out_tag.side.c1) && (out_v >= out_tag.side.c2) && ((out_v == out_tag.side.c0) || (out_v == out_tag.side.c1) || (out_v == out_tag.side.c2)))
   `ASSERT_IMPL(a_sat_zero_iff_grey, clock, reset, out_tag.valid, (out_s == 8'd0) == ((out_tag.side.c0 == out_tag.side.c1) && (out_tag.side.c1 == out_tag.side.c2)))

endmodule

// ===== rtl/rgb_hsv_color_convert.sv =====
// ----------------------------------------------------------------------------
// rgb_hsv_color_convert
// 8-bit RGB/HSV converter with darken, fully pipelined.
//
//   channel  direction  ports                                       handshake
//   request  in         req_operation, req_in_c0..2, req_darken_amount  start/busy
//   response out        rsp_out_c0..2                               rsp_valid
//
// One word enters per clock; busy stays low, so start is always taken.
// The RGB to HSV pipeline (its depth set by the two restoring dividers, two
// quotient bits per stage) feeds the HSV to RGB pipeline (region split,
// two multiplier ranks, channel select).
// Reset clears the stage valid bits only; data registers are left alone.
// rsp_valid is high for one cycle per word and the receiver cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_hsv_color_convert
   import rhc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_in_c0,
   input  logic [7:0] req_in_c1,
   input  logic [7:0] req_in_c2,
   input  logic [7:0] req_darken_amount,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_c0,
   output logic [7:0] rsp_out_c1,
   output logic [7:0] rsp_out_c2
);

   typedef struct packed {
      op_type     op;
      logic [7:0] byp0;
      logic [7:0] byp1;
      logic [7:0] byp2;
      logic [7:0] s;
      logic [7:0] v;
   } carry_type;

   typedef struct packed {
      carry_type  cr;
      logic [2:0] region;
      logic [7:0] rem;
      logic [7:0] s_inv;
   } b1_type;

   typedef struct packed {
      carry_type  cr;
      logic [2:0] region;
      logic [7:0] p;
      logic [7:0] sr;
      logic [7:0] st;
   } b2_type;

   typedef struct packed {
      carry_type  cr;
      logic [2:0] region;
      logic [7:0] p;
      logic [7:0] q;
      logic [7:0] t;
   } b3_type;

   tag_type    req_tag;
   tag_type    conv_tag;
   logic [7:0] conv_h, conv_s, conv_v;

   logic       b1_valid_ff, b2_valid_ff, b3_valid_ff, rsp_valid_ff;
   b1_type     b1_ff, b1_in;
   b2_type     b2_ff, b2_in;
   b3_type     b3_ff, b3_in;
   logic [7:0] c0_ff, c0_in;
   logic [7:0] c1_ff, c1_in;
   logic [7:0] c2_ff, c2_in;

   // Request word into the forward converter
   assign busy                = 1'b0;
   assign req_tag.valid       = start && !busy;
   assign req_tag.side.op     = op_type'(req_operation);
   assign req_tag.side.c0     = req_in_c0;
   assign req_tag.side.c1     = req_in_c1;
   assign req_tag.side.c2     = req_in_c2;
   assign req_tag.side.amount = req_darken_amount;

   rhc_rgb2hsv u_rgb2hsv (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (req_tag),
      .out_tag (conv_tag),
      .out_h   (conv_h),
      .out_s   (conv_s),
      .out_v   (conv_v)
   );

   // B1: pick HSV source, split hue into region and scaled remainder
   always_comb begin
      logic [7:0] h, base;
      b1_in.cr.op = conv_tag.side.op;
      case (conv_tag.side.op)
         OP_HSV2RGB: begin
            h           = conv_tag.side.c0;
            b1_in.cr.s  = conv_tag.side.c1;
            b1_in.cr.v  = conv_tag.side.c2;
         end
         OP_DARKEN: begin
            h           = conv_h;
            b1_in.cr.s  = conv_s;
            b1_in.cr.v  = conv_v - conv_tag.side.amount;
         end
         default: begin
            h           = conv_h;
            b1_in.cr.s  = conv_s;
            b1_in.cr.v  = conv_v;
         end
      endcase
      // forward HSV result for rgb2hsv, untouched input otherwise
      if (conv_tag.side.op == OP_RGB2HSV) begin
         b1_in.cr.byp0 = conv_h;
         b1_in.cr.byp1 = conv_s;
         b1_in.cr.byp2 = conv_v;
      end else begin
         b1_in.cr.byp0 = conv_tag.side.c0;
         b1_in.cr.byp1 = conv_tag.side.c1;
         b1_in.cr.byp2 = conv_tag.side.c2;
      end
      // region = h / 43 by threshold compare
      if (h >= 8'(5 * HUE_SECTOR)) begin
         b1_in.region = 3'd5;
         base         = 8'(5 * HUE_SECTOR);
      end else if (h >= 8'(4 * HUE_SECTOR)) begin
         b1_in.region = 3'd4;
         base         = 8'(4 * HUE_SECTOR);
      end else if (h >= 8'(3 * HUE_SECTOR)) begin
         b1_in.region = 3'd3;
         base         = 8'(3 * HUE_SECTOR);
      end else if (h >= 8'(2 * HUE_SECTOR)) begin
         b1_in.region = 3'd2;
         base         = 8'(2 * HUE_SECTOR);
      end else if (h >= HUE_SECTOR) begin
         b1_in.region = 3'd1;
         base         = HUE_SECTOR;
      end else begin
         b1_in.region = 3'd0;
         base         = 8'd0;
      end
      b1_in.rem   = 8'((h - base) * REGION_COUNT);
      b1_in.s_inv = FULL_SCALE - b1_in.cr.s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= conv_tag.valid;
      end
      b1_ff <= b1_in;
   end

   // B2: first multiplier rank, p and the two saturation terms
   always_comb begin
      logic [15:0] pp, spr, spt;
      pp  = {8'h00, b1_ff.cr.v} * {8'h00, b1_ff.s_inv};
      spr = {8'h00, b1_ff.cr.s} * {8'h00, b1_ff.rem};
      spt = {8'h00, b1_ff.cr.s} * {8'h00, FULL_SCALE - b1_ff.rem};
      b2_in.cr     = b1_ff.cr;
      b2_in.region = b1_ff.region;
      b2_in.p      = pp[15:8];
      b2_in.sr     = spr[15:8];
      b2_in.st     = spt[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= b1_valid_ff;
      end
      b2_ff <= b2_in;
   end

   // B3: second multiplier rank, q and t
   always_comb begin
      logic [15:0] qq, tt;
      qq = {8'h00, b2_ff.cr.v} * {8'h00, FULL_SCALE - b2_ff.sr};
      tt = {8'h00, b2_ff.cr.v} * {8'h00, FULL_SCALE - b2_ff.st};
      b3_in.cr     = b2_ff.cr;
      b3_in.region = b2_ff.region;
      b3_in.p      = b2_ff.p;
      b3_in.q      = qq[15:8];
      b3_in.t      = tt[15:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b3_valid_ff <= 1'b0;
      end else begin
         b3_valid_ff <= b2_valid_ff;
      end
      b3_ff <= b3_in;
   end

   // B4: channel order by region, grey short path, operation select
   always_comb begin
      logic [7:0] v, p, q, t;
      v = b3_ff.cr.v;
      p = b3_ff.p;
      q = b3_ff.q;
      t = b3_ff.t;
      case (b3_ff.region)
         3'd0: begin c0_in = v; c1_in = t; c2_in = p; end
         3'd1: begin c0_in = q; c1_in = v; c2_in = p; end
         3'd2: begin c0_in = p; c1_in = v; c2_in = t; end
         3'd3: begin c0_in = p; c1_in = q; c2_in = v; end
         3'd4: begin c0_in = t; c1_in = p; c2_in = v; end
         default: begin c0_in = v; c1_in = p; c2_in = q; end
      endcase
      if (b3_ff.cr.s == 8'd0) begin
         c0_in = v;
         c1_in = v;
         c2_in = v;
      end
      if ((b3_ff.cr.op == OP_RGB2HSV) || (b3_ff.cr.op == OP_PASS)) begin
         c0_in = b3_ff.cr.byp0;
         c1_in = b3_ff.cr.byp1;
         c2_in = b3_ff.cr.byp2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= b3_valid_ff;
      end
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_c0 = c0_ff;
   assign rsp_out_c1 = c1_ff;
   assign rsp_out_c2 = c2_ff;

   // Checks
   `ASSERT_IMPL(a_rsp_from_req, clock, reset, rsp_valid, $past(start, LATENCY))
   `ASSERT_NEXT(a_grey_rgb_out, clock, reset, b3_valid_ff && (b3_ff.cr.s == 8'd0) && ((b3_ff.cr.op == OP_HSV2RGB) || (b3_ff.cr.op == OP_DARKEN)), (rsp_out_c0 == rsp_out_c1) && (rsp_out_c1 == rsp_out_c2))

endmodule

// ===== test/rgb_hsv_color_convert_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_hsv_color_convert_tb
// Sends pixels through all four operation codes with random gaps between
// words. It works out the expected colour of every accepted word and compares
// it, channel by channel and in order, with the pixels that come out.
// ----------------------------------------------------------------------------
module rgb_hsv_color_convert_tb;
   import rhc_pkg::*;

   typedef struct packed {
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
   } pixel_type;

   localparam int unsigned RANDOM_WORDS = 1825;
   localparam int unsigned STALL_LIMIT  = 1000;

   // Expected pixels, oldest first, and the conversions that produce them
   class colour_scoreboard;
      localparam int SECTOR     = HUE_SECTOR;
      localparam int GREEN_BASE = HUE_GREEN;
      localparam int BLUE_BASE  = HUE_BLUE;
      localparam int FULL       = FULL_SCALE;
      localparam int REGIONS    = REGION_COUNT;

      pixel_type   expected_pixels[$];
      int unsigned failures;

      function new();
         failures = 0;
      endfunction

      function pixel_type to_hsv(pixel_type rgb);
         int r, g, b, lo, hi, span, sat, num, quot, base;
         pixel_type hsv;
         r = rgb.c0;
         g = rgb.c1;
         b = rgb.c2;
         lo = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
         hi = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
         hsv = '0;
         hsv.c2 = 8'(hi);
         // black and grey: no hue, no saturation
         if (hi == lo) return hsv;
         span = hi - lo;
         sat = (FULL * span / hi) & 255;
         if (sat == 0) return hsv;
         if (hi == r) begin
            base = 0;
            num = g - b;
         end else if (hi == g) begin
            base = GREEN_BASE;
            num = b - r;
         end else begin
            base = BLUE_BASE;
            num = r - g;
         end
         // signed quotient truncates toward zero, sum wraps at 8 bits
         quot = (SECTOR * num) / span;
         hsv.c0 = 8'(base + quot);
         hsv.c1 = 8'(sat);
         return hsv;
      endfunction

      function pixel_type to_rgb(pixel_type hsv);
         int h, s, v, region, rem, p, q, t;
         pixel_type rgb;
         h = hsv.c0;
         s = hsv.c1;
         v = hsv.c2;
         if (s == 0) return {8'(v), 8'(v), 8'(v)};
         region = h / SECTOR;
         rem = ((h - region * SECTOR) * REGIONS) & 255;
         p = ((v * (FULL - s)) >> 8) & 255;
         q = ((v * (FULL - ((s * rem) >> 8))) >> 8) & 255;
         t = ((v * (FULL - ((s * (FULL - rem)) >> 8))) >> 8) & 255;
         case (region)
            0:       rgb = {8'(v), 8'(t), 8'(p)};
            1:       rgb = {8'(q), 8'(v), 8'(p)};
            2:       rgb = {8'(p), 8'(v), 8'(t)};
            3:       rgb = {8'(p), 8'(q), 8'(v)};
            4:       rgb = {8'(t), 8'(p), 8'(v)};
            default: rgb = {8'(v), 8'(p), 8'(q)};
         endcase
         return rgb;
      endfunction

      function void note_pixel(op_type op, pixel_type pix, logic [7:0] amount);
         pixel_type res;
         case (op)
            OP_RGB2HSV: res = to_hsv(pix);
            OP_HSV2RGB: res = to_rgb(pix);
            OP_DARKEN: begin
               res = to_hsv(pix);
               res.c2 = res.c2 - amount;   // wraps, may brighten
               res = to_rgb(res);
            end
            default: res = pix;
         endcase
         expected_pixels.insert(expected_pixels.size(), res);
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            $error("unexpected result word %0d %0d %0d", got.c0, got.c1, got.c2);
            failures++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.c0 !== want.c0) begin
            $error("out_c0: expected %0d, got %0d", want.c0, got.c0);
            failures++;
         end
         if (got.c1 !== want.c1) begin
            $error("out_c1: expected %0d, got %0d", want.c1, got.c1);
            failures++;
         end
         if (got.c2 !== want.c2) begin
            $error("out_c2: expected %0d, got %0d", want.c2, got.c2);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_operation;
   logic [7:0] req_in_c0;
   logic [7:0] req_in_c1;
   logic [7:0] req_in_c2;
   logic [7:0] req_darken_amount;
   logic       rsp_valid;
   logic [7:0] rsp_out_c0;
   logic [7:0] rsp_out_c1;
   logic [7:0] rsp_out_c2;

   colour_scoreboard colours = new();
   int unsigned      idle_cycles = 0;
   bit               steady = 0;

   rgb_hsv_color_convert u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_in_c0         (req_in_c0),
      .req_in_c1         (req_in_c1),
      .req_in_c2         (req_in_c2),
      .req_darken_amount (req_darken_amount),
      .rsp_valid         (rsp_valid),
      .rsp_out_c0        (rsp_out_c0),
      .rsp_out_c1        (rsp_out_c1),
      .rsp_out_c2        (rsp_out_c2)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Note accepted words before checking, so zero latency would still work
   always @(posedge clock) begin
      if (!reset && start && !busy)
         colours.note_pixel(op_type'(req_operation),
                            {req_in_c0, req_in_c1, req_in_c2}, req_darken_amount);
      if (!reset && rsp_valid)
         colours.check_pixel({rsp_out_c0, rsp_out_c1, rsp_out_c2});
   end

   // Watchdog: nothing moving on either side for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // One word: optional gap with start low, then hold until taken
   task automatic send_pixel(op_type op, logic [7:0] c0, logic [7:0] c1,
                             logic [7:0] c2, logic [7:0] amount);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start             <= 1'b1;
      req_operation     <= op;
      req_in_c0         <= c0;
      req_in_c1         <= c1;
      req_in_c2         <= c2;
      req_darken_amount <= amount;
      do @(posedge clock); while (busy);
   endtask

   // Sender holds off until every expected pixel is back
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (colours.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      op_type     op;
      logic [7:0] c0, c1, c2, amount;
      int unsigned pick;

      reset             <= 1'b1;
      start             <= 1'b0;
      req_operation     <= OP_RGB2HSV;
      req_in_c0         <= '0;
      req_in_c1         <= '0;
      req_in_c2         <= '0;
      req_darken_amount <= '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // forward: black, grey, white, primaries, negative hue offsets
      send_pixel(OP_RGB2HSV, 8'd0, 8'd0, 8'd0, 8'd0);
      send_pixel(OP_RGB2HSV, 8'd128, 8'd128, 8'd128, 8'd0);
      send_pixel(OP_RGB2HSV, 8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(OP_RGB2HSV, 8'd255, 8'd0, 8'd0, 8'd0);
      send_pixel(OP_RGB2HSV, 8'd0, 8'd255, 8'd0, 8'd0);
      send_pixel(OP_RGB2HSV, 8'd0, 8'd0, 8'd255, 8'd0);
      send_pixel(OP_RGB2HSV, 8'd255, 8'd0, 8'd100, 8'd0);
      send_pixel(OP_RGB2HSV, 8'd30, 8'd200, 8'd10, 8'd0);
      send_pixel(OP_RGB2HSV, 8'd1, 8'd0, 8'd0, 8'd0);
      // back: zero saturation, every hue region, hue extremes, zero value
      send_pixel(OP_HSV2RGB, 8'd77, 8'd0, 8'd200, 8'd0);
      send_pixel(OP_HSV2RGB, 8'd0, 8'd255, 8'd255, 8'd0);
      send_pixel(OP_HSV2RGB, 8'd50, 8'd180, 8'd220, 8'd0);
      send_pixel(OP_HSV2RGB, 8'd100, 8'd90, 8'd255, 8'd0);
      send_pixel(OP_HSV2RGB, 8'd140, 8'd255, 8'd130, 8'd0);
      send_pixel(OP_HSV2RGB, 8'd180, 8'd200, 8'd60, 8'd0);
      send_pixel(OP_HSV2RGB, 8'd255, 8'd255, 8'd255, 8'd0);
      send_pixel(OP_HSV2RGB, 8'd220, 8'd255, 8'd0, 8'd0);
      // darken: black wraps to grey, no change, wrap upwards, full amount
      send_pixel(OP_DARKEN, 8'd0, 8'd0, 8'd0, 8'd1);
      send_pixel(OP_DARKEN, 8'd200, 8'd100, 8'd50, 8'd0);
      send_pixel(OP_DARKEN, 8'd10, 8'd20, 8'd30, 8'd200);
      send_pixel(OP_DARKEN, 8'd255, 8'd128, 8'd0, 8'd255);
      // unused code passes the pixel through
      send_pixel(OP_PASS, 8'd12, 8'd34, 8'd56, 8'd78);
      send_pixel(OP_PASS, 8'd255, 8'd0, 8'd255, 8'd0);
      drain();

      // random words, with back-to-back stretches and a few full drains
      for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 60 == 0)
            steady = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick < 6)
            op = OP_RGB2HSV;
         else if (pick < 12)
            op = OP_HSV2RGB;
         else if (pick < 19)
            op = OP_DARKEN;
         else
            op = OP_PASS;
         c0 = pick_level();
         c1 = pick_level();
         c2 = pick_level();
         amount = pick_level();
         if ($urandom_range(0, 9) == 0) begin
            c1 = c0;
            c2 = c0;
         end
         send_pixel(op, c0, c1, c2, amount);
         if (i % 400 == 399)
            drain();
      end

      // wind down: wait for the pipeline to empty, then a little more
      @(negedge clock);
      start <= 1'b0;
      while (colours.pending() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (colours.failures == 0 && colours.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
